FILE: hdl/phase_difference_fm_demodulator_core_assert.svh
// Assertion macros of the phase-difference FM demodulator RTL, used by the sequencer
`ifndef PHASE_DIFFERENCE_FM_DEMODULATOR_CORE_ASSERT_SVH
`define PHASE_DIFFERENCE_FM_DEMODULATOR_CORE_ASSERT_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define PDFM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while in reset
`define PDFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pdfm_pkg.sv
// Types and constants of the phase-difference FM demodulator
`default_nettype none

package pdfm_pkg;

    localparam int GAIN_W        = 16;
    localparam int COEFF_W       = 24;
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_IDX_W     = 1;
    localparam int SPLIT_BITS    = 12;
    localparam int DIV_STEP_BITS = 8;
    localparam int REM_W         = 4;

    localparam logic [REM_W:0]         SMOOTH_DIV     = 5'd10;
    localparam logic [GAIN_W-1:0]      GAIN_RESET     = 16'd4096;
    localparam logic [COEFF_W-1:0]     DC_COEFF_RESET = 24'd3495;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_COEFF = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_S,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DC_UPD,
        ST_H,
        ST_X,
        ST_ABS,
        ST_DIV,
        ST_SM_UPD,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_S,
        OP_DIFF,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DC_UPD,
        OP_H,
        OP_X,
        OP_ABS,
        OP_DIV_STEP,
        OP_SM_UPD
    } dp_op_t;

    typedef struct packed {
        logic   load_in;
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/phase_difference_fm_demodulator_core.sv
// Top level of the phase-difference FM demodulator core
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------
//  s_      | in        | s_valid / s_ready | s_phase  signed SAMPLE_WIDTH
//  m_      | out       | m_valid / m_ready | m_audio  signed SAMPLE_WIDTH
//  cfg_    | in        | cfg_wr_en         | cfg_index, cfg_wr_data (24 bits)
//
// One beat at a time: the sequencer walks one shared multiplier through three
// products, then a divide-by-ten unit taking 8 quotient bits per cycle.
// The result register frees s_ready for the next beat while m_ready is low;
// a stalled output holds the sequencer in its last step only.
// Synchronous active-low reset restores gain 4096, dc_coeff 3495, zero state.
`default_nettype none

module phase_difference_fm_demodulator_core
    import pdfm_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] s_phase,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [SAMPLE_WIDTH-1:0]      m_audio
);

    localparam int DIV_CYCLES = (SAMPLE_WIDTH + 18 + DIV_STEP_BITS - 1) / DIV_STEP_BITS;

    dp_cmd_t cmd;

    pdfm_ctrl #(
        .DIV_CYCLES (DIV_CYCLES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    pdfm_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .DIV_CYCLES     (DIV_CYCLES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .s_phase     (s_phase),
        .m_audio     (m_audio)
    );

endmodule

`default_nettype wire

FILE: hdl/pdfm_ctrl.sv
// Sequencer of the demodulator: steps the datapath through one beat
`default_nettype none
`include "phase_difference_fm_demodulator_core_assert.svh"

module pdfm_ctrl
    import pdfm_pkg::*;
#(
    parameter int DIV_CYCLES = 5
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output dp_cmd_t   cmd
);

    localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_MUL_S;
            ST_MUL_S:  state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_DC_UPD;
            ST_DC_UPD: state_next = ST_H;
            ST_H:      state_next = ST_X;
            ST_X:      state_next = ST_ABS;
            ST_ABS:    state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == CNT_LAST) state_next = ST_SM_UPD;
            ST_SM_UPD: state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '{load_in: 1'b0, op: OP_NONE, out_load: 1'b0};
        s_ready      = 1'b0;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_MUL_S:  cmd.op = OP_MUL_S;
            ST_DIFF:   cmd.op = OP_DIFF;
            ST_MUL_LO: cmd.op = OP_MUL_LO;
            ST_MUL_HI: cmd.op = OP_MUL_HI;
            ST_DC_UPD: cmd.op = OP_DC_UPD;
            ST_H:      cmd.op = OP_H;
            ST_X:      cmd.op = OP_X;
            ST_ABS: begin
                cmd.op   = OP_ABS;
                cnt_next = '0;
            end
            ST_DIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_SM_UPD: cmd.op = OP_SM_UPD;
            ST_OUT:    cmd.out_load = out_free;
            default:   cmd.op = OP_NONE;
        endcase
        // result register frees on take, refills on load
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    assign m_valid = m_valid_reg;

    // never overwrite a result that is still waiting
    `PDFM_ASSERT_NOW(a_out_load_free, cmd.out_load, !m_valid_reg || m_ready, "result overwritten")
    // divider step count stays within its pass
    `PDFM_ASSERT_NOW(a_div_cnt_range, state_reg == ST_DIV, cnt_reg <= CNT_LAST, "div count overrun")
    // one beat in flight: no accept right after an accept
    `PDFM_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second beat accepted")

endmodule

`default_nettype wire

FILE: hdl/pdfm_datapath.sv
// Datapath: phase difference, shared multiplier, DC tracker, smoother, saturation
`default_nettype none

module pdfm_datapath
    import pdfm_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 12,
    parameter int DIV_CYCLES     = 5
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire dp_cmd_t                 cmd,
    input  wire logic [SAMPLE_WIDTH-1:0] s_phase,
    output logic [SAMPLE_WIDTH-1:0]      m_audio
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int S_W  = SW + GAIN_W;          // scaled difference, DC estimate
    localparam int E_W  = S_W + 1;              // error into the DC tracker
    localparam int EH_W = E_W - SPLIT_BITS;     // upper part of the error
    localparam int H_W  = S_W + 1;              // DC-free sample, smoother state
    localparam int X_W  = H_W + 1;              // smoother step before divide
    localparam int MA_W = EH_W;
    localparam int MB_W = COEFF_W + 1;
    localparam int P_W  = MA_W + MB_W;
    localparam int T_W  = P_W + 1;
    localparam int LO_W = COEFF_W;
    localparam int QW   = DIV_CYCLES * DIV_STEP_BITS;
    localparam int Y_W  = H_W - GAIN_FRAC_BITS;

    // configuration
    logic [GAIN_W-1:0]  gain_reg, gain_next;
    logic [COEFF_W-1:0] coeff_reg, coeff_next;
    // block state
    logic [SW-1:0]      last_phase_reg, last_phase_next;
    logic [S_W-1:0]     dc_reg, dc_next;
    logic [H_W-1:0]     sm_reg, sm_next;
    // working registers
    logic [SW-1:0]      d_reg, d_next;
    logic [P_W-1:0]     prod_reg, prod_next;
    logic [S_W-1:0]     s_reg, s_next;
    logic [E_W-1:0]     e_reg, e_next;
    logic [LO_W-1:0]    lo_reg, lo_next;
    logic [H_W-1:0]     h_reg, h_next;
    logic [X_W-1:0]     x_reg, x_next;
    logic               neg_reg, neg_next;
    logic [QW-1:0]      q_reg, q_next;
    logic [REM_W-1:0]   r_reg, r_next;
    logic [SW-1:0]      audio_reg, audio_next;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  mul_p;
    logic [T_W-1:0]         t_sum;
    logic [X_W-1:0]         x_mag;
    logic [H_W-1:0]         q_trim;
    logic [QW-1:0]          q_step;
    logic [REM_W-1:0]       r_step;
    logic [Y_W-1:0]         y_val;
    logic                   y_fits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg       <= GAIN_RESET;
            coeff_reg      <= DC_COEFF_RESET;
            last_phase_reg <= '0;
            dc_reg         <= '0;
            sm_reg         <= '0;
        end else begin
            gain_reg       <= gain_next;
            coeff_reg      <= coeff_next;
            last_phase_reg <= last_phase_next;
            dc_reg         <= dc_next;
            sm_reg         <= sm_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg     <= d_next;
        prod_reg  <= prod_next;
        s_reg     <= s_next;
        e_reg     <= e_next;
        lo_reg    <= lo_next;
        h_reg     <= h_next;
        x_reg     <= x_next;
        neg_reg   <= neg_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        audio_reg <= audio_next;
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_S: begin
                mul_a = {{(MA_W - SW){d_reg[SW-1]}}, d_reg};
                mul_b = {{(MB_W - GAIN_W){1'b0}}, gain_reg};
            end
            OP_MUL_LO: begin
                mul_a = {{(MA_W - SPLIT_BITS){1'b0}}, e_reg[SPLIT_BITS-1:0]};
                mul_b = {1'b0, coeff_reg};
            end
            OP_MUL_HI: begin
                mul_a = e_reg[E_W-1:SPLIT_BITS];
                mul_b = {1'b0, coeff_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // exact floor(e * coeff / 2^24) = (hi * coeff + (lo * coeff >> 12)) >> 12
    assign t_sum = {prod_reg[P_W-1], prod_reg} + T_W'(lo_reg);
    assign x_mag = (x_reg ^ {X_W{x_reg[X_W-1]}}) + X_W'(x_reg[X_W-1]);
    assign q_trim = q_reg[H_W-1:0];

    // restoring divide by ten, several quotient bits per cycle
    always_comb begin
        logic [REM_W:0] r5;
        r5     = '0;
        q_step = q_reg;
        r_step = r_reg;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            r5     = {r_step, q_step[QW-1]};
            q_step = {q_step[QW-2:0], (r5 >= SMOOTH_DIV)};
            r_step = (r5 >= SMOOTH_DIV) ? REM_W'(r5 - SMOOTH_DIV) : r5[REM_W-1:0];
        end
    end

    // floor shift back to sample units, then clamp
    assign y_val  = sm_reg[H_W-1:GAIN_FRAC_BITS];
    assign y_fits = (&y_val[Y_W-1:SW-1]) || !(|y_val[Y_W-1:SW-1]);

    always_comb begin
        gain_next       = gain_reg;
        coeff_next      = coeff_reg;
        last_phase_next = last_phase_reg;
        dc_next         = dc_reg;
        sm_next         = sm_reg;
        d_next          = d_reg;
        prod_next       = prod_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        lo_next         = lo_reg;
        h_next          = h_reg;
        x_next          = x_reg;
        neg_next        = neg_reg;
        q_next          = q_reg;
        r_next          = r_reg;
        audio_next      = audio_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GAIN:     gain_next  = cfg_wr_data[GAIN_W-1:0];
                CFG_DC_COEFF: coeff_next = cfg_wr_data[COEFF_W-1:0];
                default:      gain_next  = gain_reg;
            endcase
        end

        if (cmd.load_in) begin
            d_next          = s_phase - last_phase_reg;    // wraps into +/- pi
            last_phase_next = s_phase;
        end

        case (cmd.op)
            OP_MUL_S: prod_next = mul_p;
            OP_DIFF: begin
                s_next = prod_reg[S_W-1:0];
                e_next = {prod_reg[S_W-1], prod_reg[S_W-1:0]} - {dc_reg[S_W-1], dc_reg};
            end
            OP_MUL_LO: prod_next = mul_p;
            OP_MUL_HI: begin
                lo_next   = prod_reg[LO_W+SPLIT_BITS-1:SPLIT_BITS];
                prod_next = mul_p;
            end
            OP_DC_UPD: dc_next = dc_reg + t_sum[SPLIT_BITS+S_W-1:SPLIT_BITS];
            OP_H:      h_next  = {s_reg[S_W-1], s_reg} - {dc_reg[S_W-1], dc_reg};
            OP_X:      x_next  = {h_reg[H_W-1], h_reg} - {sm_reg[H_W-1], sm_reg};
            OP_ABS: begin
                neg_next = x_reg[X_W-1];
                q_next   = QW'(x_mag);
                r_next   = '0;
            end
            OP_DIV_STEP: begin
                q_next = q_step;
                r_next = r_step;
            end
            // quotient truncates toward zero: apply the sign after the divide
            OP_SM_UPD: sm_next = sm_reg + (q_trim ^ {H_W{neg_reg}}) + H_W'(neg_reg);
            default:   prod_next = prod_reg;
        endcase

        if (cmd.out_load) begin
            audio_next = y_fits ? y_val[SW-1:0] : {y_val[Y_W-1], {(SW-1){~y_val[Y_W-1]}}};
        end
    end

    assign m_audio = audio_reg;

endmodule

`default_nettype wire

FILE: sim/tb_phase_difference_fm_demodulator_core.sv
// Self-checking testbench for the phase-difference FM demodulator core
`timescale 1ns / 1ps

module tb_phase_difference_fm_demodulator_core;
    import pdfm_pkg::*;

    localparam int     SW          = 16;
    localparam int     GFB         = 12;
    localparam int     IDLE_PCT    = 8;
    localparam int     DRAIN_WAIT  = 40;
    localparam int     STALL_LIMIT = 2000;
    localparam longint SMOOTH_DEN  = 10;
    localparam longint AUDIO_MAX   = 32767;
    localparam longint AUDIO_MIN   = -32768;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [SW-1:0]         s_phase     = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [SW-1:0]         m_audio;

    // predictor copy of registers and state
    logic [GAIN_W-1:0]  gain_reg   = GAIN_RESET;
    logic [COEFF_W-1:0] coeff_reg  = DC_COEFF_RESET;
    logic [SW-1:0]      prev_phase = '0;
    longint             dc_est     = 0;
    longint             smooth_acc = 0;

    logic [SW-1:0] phase_backlog[$];
    logic [SW-1:0] audio_due[$];

    logic no_idle = 1'b0;
    logic hold_tx = 1'b0;
    int   mismatches = 0;
    int   stall_cycles = 0;

    int reset_cfg_phases[$] = '{20000, 0, 32767, -32768, 0, 16384, -16384, 16384,
                                32767, -32768, 32767, -32768, 0, 0, 0, 1, -1,
                                100, 200, 300};

    phase_difference_fm_demodulator_core #(
        .SAMPLE_WIDTH   (SW),
        .GAIN_FRAC_BITS (GFB)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_phase     (s_phase),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_audio     (m_audio)
    );

    always #6 aclk = ~aclk;

    function automatic logic [SW-1:0] demod_sample(input logic [SW-1:0] ph);
        logic signed [SW-1:0] dphase;
        longint               scaled;
        longint               err;
        longint               hp;
        longint               y;
        dphase = ph - prev_phase;   // 16-bit wrap is the wrap into +/- pi
        prev_phase = ph;
        scaled = longint'(dphase) * longint'({48'd0, gain_reg});
        err = scaled - dc_est;
        dc_est += (err * longint'({40'd0, coeff_reg})) >>> COEFF_W;
        hp = scaled - dc_est;
        smooth_acc += (hp - smooth_acc) / SMOOTH_DEN;   // truncates toward zero
        y = smooth_acc >>> GFB;
        if (y > AUDIO_MAX) y = AUDIO_MAX;
        if (y < AUDIO_MIN) y = AUDIO_MIN;
        return y[SW-1:0];
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // driver: new beat only once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) audio_due.push_back(demod_sample(s_phase));
            if (phase_backlog.size() != 0 && !hold_tx &&
                (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_valid <= 1'b1;
                s_phase <= phase_backlog.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin : monitor
        logic [SW-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (audio_due.size() == 0) begin
                flag_mismatch($sformatf("audio beat %0d with none pending",
                                        $signed(m_audio)));
            end else begin
                want = audio_due.pop_front();
                if (m_audio !== want)
                    flag_mismatch($sformatf("audio got %0d want %0d",
                                            $signed(m_audio), $signed(want)));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("phase_difference_fm_demodulator_core regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GAIN:     gain_reg = data[GAIN_W-1:0];
            CFG_DC_COEFF: coeff_reg = data[COEFF_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (phase_backlog.size() != 0 || s_valid || audio_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    // mostly FM-like ramps (random tone + jitter), some raw noise
    task automatic queue_random(input int count);
        int            left;
        int            seg_len;
        logic [SW-1:0] tone_phase;
        logic [SW-1:0] step;
        left = count;
        tone_phase = 16'($urandom);
        while (left > 0) begin
            seg_len = $urandom_range(4, 40);
            if (seg_len > left) seg_len = left;
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 1) == 1)
                    step = 16'($urandom_range(0, 4095)) - 16'd2048;
                else
                    step = 16'($urandom);
                repeat (seg_len) begin
                    tone_phase = tone_phase + step + 16'($urandom_range(0, 63)) - 16'd32;
                    phase_backlog.push_back(tone_phase);
                end
            end else begin
                repeat (seg_len) phase_backlog.push_back(16'($urandom));
            end
            left -= seg_len;
        end
    endtask

    initial begin : sequencer
        logic [SW-1:0] ramp;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: first beat after reset, field extremes, pi steps
        foreach (reset_cfg_phases[i]) phase_backlog.push_back(16'(reset_cfg_phases[i]));
        drain();

        // max gain and coefficient; junk above the gain field must be dropped
        write_reg(CFG_GAIN, {8'hA5, 16'hFFFF});
        write_reg(CFG_DC_COEFF, 24'hFFFFFF);
        ramp = '0;
        repeat (8) begin
            ramp = ramp + 16'd16384;
            phase_backlog.push_back(ramp);
        end
        repeat (8) begin
            ramp = ramp - 16'd16384;
            phase_backlog.push_back(ramp);
        end
        no_idle = 1'b1;
        queue_random(250);
        drain();
        no_idle = 1'b0;

        write_reg(CFG_GAIN, 24'h000000);
        write_reg(CFG_DC_COEFF, 24'h000001);
        queue_random(150);
        drain();

        // zero coefficient: DC estimate frozen
        write_reg(CFG_GAIN, {8'($urandom), GAIN_RESET});
        write_reg(CFG_DC_COEFF, 24'h000000);
        queue_random(150);
        drain();

        repeat (3) begin
            write_reg(CFG_GAIN, {8'($urandom), 16'($urandom_range(0, 65535))});
            write_reg(CFG_DC_COEFF, 24'($urandom_range(1, 24'hFFFFFF)));
            queue_random(150);
            drain();
        end

        // sender holds off until the pipe is empty, then resumes
        write_reg(CFG_GAIN, 24'd8192);
        write_reg(CFG_DC_COEFF, DC_COEFF_RESET);
        queue_random(75);
        while (phase_backlog.size() > 30) @(negedge aclk);
        hold_tx = 1'b1;
        while (s_valid || audio_due.size() != 0) @(negedge aclk);
        hold_tx = 1'b0;
        queue_random(75);
        drain();

        if (audio_due.size() != 0)
            flag_mismatch($sformatf("%0d audio beats never arrived", audio_due.size()));
        if (mismatches == 0) begin
            $display("phase_difference_fm_demodulator_core regression: pass");
        end else begin
            $display("phase_difference_fm_demodulator_core regression: fail");
        end
        $finish;
    end

endmodule
